// File: rtl/srtx_pkg.sv
// Shared types and constants for the signed integer to radix text block.
package srtx_pkg;

  // Input word and configuration port geometry
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CFG_WORDS    = 8;
  localparam int unsigned CFG_WORD_W   = $clog2(CFG_WORDS);
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CHAR_W       = 8;

  // Alphabet storage: eight bytes per configuration word
  localparam int unsigned SYM_CAP      = 64;
  localparam int unsigned SYM_IDX_W    = $clog2(SYM_CAP);
  localparam int unsigned MAX_SYMBOLS_DEF = 64;

  // Divider: quotient bits resolved per cycle and cycles per digit
  localparam int unsigned BITS_PER_CYC = 8;
  localparam int unsigned DIV_CYCLES   = VAL_W / BITS_PER_CYC;
  localparam int unsigned STEP_W       = $clog2(DIV_CYCLES);

  // Digit buffer: radix 2 on magnitude 2^31 gives the most digits
  localparam int unsigned DIG_BUF      = VAL_W;
  localparam int unsigned BUF_W        = $clog2(DIG_BUF);

  // Character codes
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] DEL_CHAR   = 8'h7F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic put_sign;
    logic put_digit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic neg;
    logic digit_done;
    logic quot_zero;
    logic out_free;
    logic last_digit;
  } dp_sts_t;

  // Alphabet checker to controller
  typedef struct packed {
    logic busy;
    logic ok;
  } alpha_sts_t;

endpackage

// File: rtl/srtx_alpha.sv
// Alphabet registers, symbol lookup and alphabet validity scan.
module srtx_alpha import srtx_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  localparam int unsigned RADIX_W = $clog2(MAX_SYMBOLS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SYM_IDX_W-1:0]  sym_idx_i,
  output logic [CHAR_W-1:0]     sym_o,
  output logic [RADIX_W-1:0]    radix_o,
  output alpha_sts_t            sts_o
);

  logic [CFG_DATA_W-1:0] cfg_q [CFG_WORDS];
  logic [CHAR_W-1:0]     sym [SYM_CAP];

  logic               busy_q;
  logic               bad_q;
  logic               ok_q;
  logic [RADIX_W-1:0] idx_q;
  logic [RADIX_W-1:0] len_q;

  logic [CHAR_W-1:0]  cur;
  logic               at_end;
  logic               dup;
  logic               bad_now;

  always_comb begin
    for (int w = 0; w < CFG_WORDS; w++) begin
      for (int b = 0; b < CFG_DATA_W / CHAR_W; b++) begin
        sym[w * (CFG_DATA_W / CHAR_W) + b] = cfg_q[w][b * CHAR_W +: CHAR_W];
      end
    end
  end

  assign sym_o = sym[sym_idx_i];

  // Scan one symbol per cycle; compare it with every earlier symbol
  assign cur    = sym[SYM_IDX_W'(idx_q)];
  assign at_end = (idx_q == RADIX_W'(MAX_SYMBOLS)) || (cur == '0);

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if ((RADIX_W'(j) < idx_q) && (sym[j] == cur)) begin
        dup = 1'b1;
      end
    end
  end

  assign bad_now = dup || (cur == MINUS_CHAR) || (cur == PLUS_CHAR) ||
                   (cur <= SPACE_CHAR) || (cur == DEL_CHAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < CFG_WORDS; w++) begin
        cfg_q[w] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(CFG_WORDS))) begin
      cfg_q[cfg_index_i[CFG_WORD_W-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bad_q  <= 1'b0;
      ok_q   <= 1'b0;
      idx_q  <= '0;
      len_q  <= '0;
    end else if (cfg_valid_i) begin
      busy_q <= 1'b1;
      bad_q  <= 1'b0;
      idx_q  <= '0;
    end else if (busy_q) begin
      if (at_end) begin
        busy_q <= 1'b0;
        ok_q   <= !bad_q && (idx_q >= RADIX_W'(2));
        len_q  <= idx_q;
      end else begin
        idx_q <= idx_q + RADIX_W'(1);
        bad_q <= bad_q || bad_now;
      end
    end
  end

  assign radix_o    = len_q;
  assign sts_o.busy = busy_q;
  assign sts_o.ok   = ok_q;

endmodule

// File: rtl/srtx_dpath.sv
// Datapath: magnitude, digit divider, digit buffer and output register.
module srtx_dpath import srtx_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  localparam int unsigned RADIX_W = $clog2(MAX_SYMBOLS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_sts_t              sts_o,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [RADIX_W-1:0]   radix_i,
  output logic [SYM_IDX_W-1:0] sym_idx_o,
  input  logic [CHAR_W-1:0]    sym_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [CHAR_W-1:0]    character_o,
  output logic                 last_o
);

  localparam int unsigned DIG_W = $clog2(MAX_SYMBOLS);
  localparam int unsigned T_W   = DIG_W + 1;

  logic [VAL_W-1:0]  q_q;
  logic [DIG_W-1:0]  rem_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic [BUF_W-1:0]  wr_q;
  logic [BUF_W-1:0]  rd_q;
  logic [DIG_W-1:0]  dig_q [DIG_BUF];
  logic              out_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  logic [VAL_W-1:0]  mag;
  logic [VAL_W-1:0]  quot;
  logic [DIG_W-1:0]  rem_w;
  logic [T_W-1:0]    trial;
  logic              digit_done;
  logic              out_free;

  assign mag = value_i[VAL_W-1] ? (VAL_W'(0) - $unsigned(value_i)) : $unsigned(value_i);

  // Restoring division, BITS_PER_CYC quotient bits per cycle
  always_comb begin
    rem_w = (step_q == '0) ? '0 : rem_q;
    quot  = q_q;
    trial = '0;
    for (int k = 0; k < BITS_PER_CYC; k++) begin
      trial = {rem_w, quot[VAL_W-1]};
      quot  = {quot[VAL_W-2:0], 1'b0};
      if (trial >= T_W'(radix_i)) begin
        trial   = trial - T_W'(radix_i);
        quot[0] = 1'b1;
      end
      rem_w = trial[DIG_W-1:0];
    end
  end

  assign digit_done = (step_q == STEP_W'(DIV_CYCLES - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
        wr_q   <= '0;
        neg_q  <= value_i[VAL_W-1];
      end else if (cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
        if (digit_done) begin
          rd_q <= wr_q;
          wr_q <= wr_q + BUF_W'(1);
        end
      end else if (cmd_i.put_digit) begin
        rd_q <= rd_q - BUF_W'(1);
      end

      if (cmd_i.put_sign || cmd_i.put_digit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_q <= mag;
    end else if (cmd_i.div_step) begin
      q_q   <= quot;
      rem_q <= rem_w;
      if (digit_done) begin
        dig_q[wr_q] <= rem_w;
      end
    end

    if (cmd_i.put_sign) begin
      char_q <= MINUS_CHAR;
      last_q <= 1'b0;
    end else if (cmd_i.put_digit) begin
      char_q <= sym_i;
      last_q <= (rd_q == '0);
    end
  end

  assign sym_idx_o = SYM_IDX_W'(dig_q[rd_q]);

  assign sts_o.neg        = neg_q;
  assign sts_o.digit_done = digit_done;
  assign sts_o.quot_zero  = (quot == '0);
  assign sts_o.out_free   = out_free;
  assign sts_o.last_digit = (rd_q == '0);

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// File: rtl/srtx_ctrl.sv
// Controller state machine: accept, divide, sign and digit emission.
module srtx_ctrl import srtx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  alpha_sts_t alpha_i,
  input  dp_sts_t    dp_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign in_stall_o = (state_q != ST_IDLE) || alpha_i.busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && alpha_i.ok) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (dp_i.digit_done && dp_i.quot_zero) begin
          state_d = dp_i.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (dp_i.out_free) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (dp_i.out_free && dp_i.last_digit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:   cmd_o.load      = accept && alpha_i.ok;
      ST_DIVIDE: cmd_o.div_step  = 1'b1;
      ST_SIGN:   cmd_o.put_sign  = dp_i.out_free;
      ST_EMIT:   cmd_o.put_digit = dp_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/signed_int_to_radix_text.sv
// Top level: signed 32-bit value to text in a configurable radix alphabet.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | to block  | in_valid_i/in_stall_o | value_i
//   out     | from block| out_valid_o/out_stall_i| character_o, last_o
//   cfg     | to block  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Each digit is resolved by the shared restoring divider (8 quotient bits
// per cycle), then every character (sign first, then digits) goes through
// the output register. An item is dropped when the alphabet is invalid.
// A configuration write starts an alphabet scan of up to MAX_SYMBOLS
// symbols, one symbol per cycle; input is stalled until it finishes.
// Reset clears all alphabet words, which leaves an invalid alphabet.
// An output stall holds the character register and the emission counter.
module signed_int_to_radix_text import srtx_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // item input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [VAL_W-1:0] value_i,
  // character output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CHAR_W-1:0]       character_o,
  output logic                    last_o,
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned RADIX_W = $clog2(MAX_SYMBOLS + 1);

  alpha_sts_t           alpha_sts;
  dp_sts_t              dp_sts;
  ctrl_cmd_t            cmd;
  logic [RADIX_W-1:0]   radix;
  logic [SYM_IDX_W-1:0] sym_idx;
  logic [CHAR_W-1:0]    sym;

  // Take every configuration word at once; the user must make writes only while idle, the block has no check for it
  assign cfg_ready_o = 1'b1;

  // Alphabet words, validity scan and the symbol lookup for emission
  srtx_alpha #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_alpha (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sym_idx_i   (sym_idx),
    .sym_o       (sym),
    .radix_o     (radix),
    .sts_o       (alpha_sts)
  );

  // Sequence the item: hold input while busy, step the divider, emit text
  srtx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .alpha_i    (alpha_sts),
    .dp_i       (dp_sts),
    .cmd_o      (cmd)
  );

  // Divider, digit buffer (least significant digit written first, read back
  // from the top) and the output register
  srtx_dpath #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (dp_sts),
    .value_i     (value_i),
    .radix_i     (radix),
    .sym_idx_o   (sym_idx),
    .sym_i       (sym),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // A write must restart the alphabet scan on the next cycle
  a_cfg_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> alpha_sts.busy)
    else $error("alphabet scan not started after configuration write");

  // No item may enter while the alphabet is being scanned
  a_scan_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_sts.busy |-> in_stall_o)
    else $error("input open during alphabet scan");

  // A valid alphabet always gives a usable radix
  a_radix_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_sts.ok && !alpha_sts.busy |-> radix >= RADIX_W'(2))
    else $error("valid alphabet with radix below two");

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.div_step, cmd.put_sign, cmd.put_digit}))
    else $error("conflicting datapath commands");

endmodule
